// ===== hw/rtl/pau_pkg.sv =====
// Shared constants, codes and types of the 2x pixel-art upscaler.
`default_nettype none

package pau_pkg;

    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 1024;

    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COLS_CNT_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROWS_CNT_W = $clog2(MAX_ROWS + 1);

    localparam int PIX_W       = 8;
    localparam int NUM_ROWS_W  = 11;
    localparam int NUM_COLS_W  = 10;
    localparam int BLK_ROW_W   = 10;
    localparam int BLK_COL_W   = 9;
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 4;
    localparam int REG_IDX_W   = 2;

    localparam int NUM_SLOTS   = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam int NUM_ROWS_RESET = 128;
    localparam int NUM_COLS_RESET = 128;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NUM_ROWS    = 2'd0,
        REG_NUM_COLUMNS = 2'd1,
        REG_TILED_MODE  = 2'd2
    } reg_idx_t;

    // Position of an output block relative to the pixel that completes it.
    typedef enum logic [1:0] {
        SLOT_UL = 2'd0,
        SLOT_UR = 2'd1,
        SLOT_LL = 2'd2,
        SLOT_LR = 2'd3
    } slot_t;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [ROWS_CNT_W-1:0] rows;
        logic [COLS_CNT_W-1:0] cols;
        logic                  tiled;
    } size_cfg_t;

    // One accepted pixel with every neighbor value its blocks need.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        pix_t                 cur;
        pix_t                 left;
        pix_t                 up_left;
        pix_t                 up;
        pix_t                 first_left;
        pix_t                 first_cur;
        pix_t                 first_start;
        pix_t                 row_start;
        pix_t                 prior_start;
    } item_rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pixel_art_2x_upscaler.sv =====
// Top level of the 2x pixel-art upscaler: register port and the three stages.
// A block reaches the result channel via the front stage register, a queue entry and
// the output register. Throughput: one pixel per cycle in unless the queue is full,
// and one block per cycle out while m_ready is high; a pixel with several blocks
// holds the back end, and a 4-entry queue absorbs it.
// Reset clears the scan counters, the left and row-start pixels, all handshake state;
// the two line stores and the first pixel are not cleared and need no clearing pass.
`default_nettype none

module pixel_art_2x_upscaler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pau_pkg::PADDR_W-1:0]    paddr,
    input  logic [pau_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pau_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pau_pkg::PIX_W-1:0]      s_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pau_pkg::BLK_ROW_W-1:0]  m_block_row,
    output logic [pau_pkg::BLK_COL_W-1:0]  m_block_column,
    output logic [pau_pkg::PIX_W-1:0]      m_out_top_left,
    output logic [pau_pkg::PIX_W-1:0]      m_out_top_right,
    output logic [pau_pkg::PIX_W-1:0]      m_out_bottom_left,
    output logic [pau_pkg::PIX_W-1:0]      m_out_bottom_right,
    output logic                           m_last_block
);
    import pau_pkg::*;

    logic [NUM_ROWS_W-1:0] num_rows_reg;
    logic [NUM_COLS_W-1:0] num_columns_reg;
    logic                  tiled_mode_reg;
    logic                  cfg_wr;
    reg_idx_t              reg_idx;
    size_cfg_t             cfg;

    logic      push_valid, push_ready, head_valid, pop;
    item_rec_t push_rec, head_rec;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:PADDR_W-REG_IDX_W]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg    <= NUM_ROWS_W'(NUM_ROWS_RESET);
            num_columns_reg <= NUM_COLS_W'(NUM_COLS_RESET);
            tiled_mode_reg  <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_NUM_ROWS:    num_rows_reg    <= pwdata[NUM_ROWS_W-1:0];
                REG_NUM_COLUMNS: num_columns_reg <= pwdata[NUM_COLS_W-1:0];
                REG_TILED_MODE:  tiled_mode_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NUM_ROWS:    prdata = APB_DATA_W'(num_rows_reg);
            REG_NUM_COLUMNS: prdata = APB_DATA_W'(num_columns_reg);
            REG_TILED_MODE:  prdata = APB_DATA_W'(tiled_mode_reg);
            default:         prdata = '0;
        endcase
    end

    // Zero sizes count as one and oversized values saturate at 1024 rows and 512 columns.
    always_comb begin
        if (num_rows_reg == '0) begin
            cfg.rows = ROWS_CNT_W'(1);
        end else if (int'(num_rows_reg) > MAX_ROWS) begin
            cfg.rows = ROWS_CNT_W'(MAX_ROWS);
        end else begin
            cfg.rows = ROWS_CNT_W'(num_rows_reg);
        end
        if (num_columns_reg == '0) begin
            cfg.cols = COLS_CNT_W'(1);
        end else if (int'(num_columns_reg) > MAX_COLUMNS) begin
            cfg.cols = COLS_CNT_W'(MAX_COLUMNS);
        end else begin
            cfg.cols = COLS_CNT_W'(num_columns_reg);
        end
        cfg.tiled = tiled_mode_reg;
    end

    pau_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .push_ready (push_ready)
    );

    pau_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop)
    );

    pau_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .head_valid         (head_valid),
        .head_rec           (head_rec),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_block_row        (m_block_row),
        .m_block_column     (m_block_column),
        .m_out_top_left     (m_out_top_left),
        .m_out_top_right    (m_out_top_right),
        .m_out_bottom_left  (m_out_bottom_left),
        .m_out_bottom_right (m_out_bottom_right),
        .m_last_block       (m_last_block)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pau_front.sv =====
// Front end: pixel intake, scan counters, line stores and block classification.
`default_nettype none

module pau_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pau_pkg::size_cfg_t        cfg,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [pau_pkg::PIX_W-1:0] s_pixel,
    output logic                      push_valid,
    output pau_pkg::item_rec_t        push_rec,
    input  logic                      push_ready
);
    import pau_pkg::*;

    logic                  accept;
    logic [COL_W-1:0]      col_cnt_reg, col_cnt_next, col;
    logic [ROW_W-1:0]      row_cnt_reg, row_cnt_next, row;
    logic [COLS_CNT_W-1:0] col_plus;
    logic [ROWS_CNT_W-1:0] row_plus;
    logic                  last_col, last_row;
    logic [NUM_SLOTS-1:0]  mask_new;

    pix_t left_reg, row_start_reg, prior_start_reg, first_start_reg;
    pix_t row_start_new, prior_start_new;

    // Each pixel waits here before it goes into the previous-row store.
    logic             pend_valid_reg;
    logic [COL_W-1:0] pend_addr_reg;
    pix_t             pend_data_reg;
    logic             pend_last_reg;
    logic             prior_we, byp;

    pix_t prior_mem [MAX_COLUMNS];
    pix_t first_mem [MAX_COLUMNS];
    pix_t prior_rd_reg, first_rd_reg;

    logic                 s1_valid_reg, s1_advance;
    logic [NUM_SLOTS-1:0] s1_mask_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [COL_W-1:0]     s1_col_reg;
    pix_t                 s1_cur_reg, s1_left_reg, s1_row_start_reg;
    pix_t                 s1_prior_start_reg, s1_first_start_reg, s1_byp_data_reg;
    logic                 s1_first_row_reg, s1_byp_reg;
    pix_t                 up_prev_reg, first_prev_reg;
    pix_t                 up, first_left, first_cur;

    // Counters past a shrunken size restart at zero before the pixel is used.
    always_comb begin
        col = (COLS_CNT_W'(col_cnt_reg) >= cfg.cols) ? '0 : col_cnt_reg;
        row = (ROWS_CNT_W'(row_cnt_reg) >= cfg.rows) ? '0 : row_cnt_reg;
        col_plus = COLS_CNT_W'(col) + COLS_CNT_W'(1);
        row_plus = ROWS_CNT_W'(row) + ROWS_CNT_W'(1);
        last_col = (col_plus == cfg.cols);
        last_row = (row_plus == cfg.rows);

        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept) begin
            col_cnt_next = last_col ? '0 : COL_W'(col_plus);
            row_cnt_next = row;
            if (last_col) begin
                row_cnt_next = last_row ? '0 : ROW_W'(row_plus);
            end
        end

        row_start_new   = (col == '0) ? s_pixel : row_start_reg;
        prior_start_new = (col == '0) ? row_start_reg : prior_start_reg;

        mask_new          = '0;
        mask_new[SLOT_UL] = (row != '0) && (col != '0);
        mask_new[SLOT_UR] = (row != '0) && last_col;
        mask_new[SLOT_LL] = last_row && (col != '0);
        mask_new[SLOT_LR] = last_row && last_col;

        // A waiting pixel is dropped only when the row restarted early.
        prior_we = accept && pend_valid_reg && ((col != '0) || pend_last_reg);
        byp      = prior_we && (pend_addr_reg == col);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg     <= '0;
            row_cnt_reg     <= '0;
            left_reg        <= '0;
            row_start_reg   <= '0;
            prior_start_reg <= '0;
            pend_valid_reg  <= 1'b0;
        end else begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (accept) begin
                left_reg        <= s_pixel;
                row_start_reg   <= row_start_new;
                prior_start_reg <= prior_start_new;
                pend_valid_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_addr_reg <= col;
            pend_data_reg <= s_pixel;
            pend_last_reg <= last_col;
            if ((row == '0) && (col == '0)) begin
                first_start_reg <= s_pixel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prior_we) begin
            prior_mem[pend_addr_reg] <= pend_data_reg;
        end
        if (accept) begin
            prior_rd_reg <= prior_mem[col];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (row == '0)) begin
            first_mem[col] <= s_pixel;
        end
        if (accept) begin
            first_rd_reg <= first_mem[col];
        end
    end

    always_comb begin
        up         = s1_byp_reg ? s1_byp_data_reg : prior_rd_reg;
        // A row-zero pixel goes into the first-row store at its own transfer, after the read.
        first_cur  = s1_first_row_reg ? s1_cur_reg : first_rd_reg;
        first_left = first_prev_reg;

        push_valid = s1_valid_reg && (s1_mask_reg != '0);
        s1_advance = s1_valid_reg && ((s1_mask_reg == '0) || push_ready);
        s_ready    = !s1_valid_reg || s1_advance;
        accept     = s_valid && s_ready;

        push_rec.mask        = s1_mask_reg;
        push_rec.row         = s1_row_reg;
        push_rec.col         = s1_col_reg;
        push_rec.cur         = s1_cur_reg;
        push_rec.left        = s1_left_reg;
        push_rec.up_left     = up_prev_reg;
        push_rec.up          = up;
        push_rec.first_left  = cfg.tiled ? first_left : '0;
        push_rec.first_cur   = cfg.tiled ? first_cur : '0;
        push_rec.first_start = cfg.tiled ? s1_first_start_reg : '0;
        push_rec.row_start   = cfg.tiled ? s1_row_start_reg : '0;
        push_rec.prior_start = cfg.tiled ? s1_prior_start_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mask_reg        <= mask_new;
            s1_row_reg         <= row;
            s1_col_reg         <= col;
            s1_cur_reg         <= s_pixel;
            s1_left_reg        <= left_reg;
            s1_row_start_reg   <= row_start_new;
            s1_prior_start_reg <= prior_start_new;
            s1_first_start_reg <= ((row == '0) && (col == '0)) ? s_pixel : first_start_reg;
            s1_first_row_reg   <= (row == '0);
            s1_byp_reg         <= byp;
            s1_byp_data_reg    <= pend_data_reg;
        end
        if (s1_advance) begin
            up_prev_reg    <= up;
            first_prev_reg <= first_cur;
        end
    end

`ifndef ASSERT_OFF
    a_prior_wr_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (prior_we && (col != '0)) |-> (COL_W'(pend_addr_reg + COL_W'(1)) == col))
        else $error("previous-row store written away from the left neighbor");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pau_queue.sv =====
// Short FIFO of classified pixel records between the front and back ends.
`default_nettype none

module pau_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  pau_pkg::item_rec_t push_rec,
    output logic               head_valid,
    output pau_pkg::item_rec_t head_rec,
    input  logic               pop
);
    import pau_pkg::*;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    item_rec_t         q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;

    always_comb begin
        push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
        head_valid = (count_reg != '0);
        head_rec   = q_mem_reg[rd_ptr_reg];
        push       = push_valid && push_ready;

        wr_ptr_next = wr_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(wr_ptr_reg + QPTR_W'(1));
        end
        rd_ptr_next = rd_ptr_reg;
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(rd_ptr_reg + QPTR_W'(1));
        end

        count_next = count_reg;
        if (push && !pop) begin
            count_next = QCNT_W'(count_reg + QCNT_W'(1));
        end else if (pop && !push) begin
            count_next = QCNT_W'(count_reg - QCNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pau_back.sv =====
// Back end: walks the blocks of each record and applies the diagonal rules.
`default_nettype none

module pau_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  pau_pkg::item_rec_t            head_rec,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pau_pkg::BLK_ROW_W-1:0] m_block_row,
    output logic [pau_pkg::BLK_COL_W-1:0] m_block_column,
    output logic [pau_pkg::PIX_W-1:0]     m_out_top_left,
    output logic [pau_pkg::PIX_W-1:0]     m_out_top_right,
    output logic [pau_pkg::PIX_W-1:0]     m_out_bottom_left,
    output logic [pau_pkg::PIX_W-1:0]     m_out_bottom_right,
    output logic                          m_last_block
);
    import pau_pkg::*;

    logic [NUM_SLOTS-1:0] done_reg, done_next, rem, sel_bit, rem_after;
    slot_t                slot;
    logic                 load, finish;
    pix_t                 w_tl, w_tr, w_bl, w_br;
    pix_t                 o_tr, o_bl, o_br;
    logic [ROW_W-1:0]     blk_row;
    logic [COL_W-1:0]     blk_col;

    logic                 m_valid_reg;
    logic [BLK_ROW_W-1:0] row_out_reg;
    logic [BLK_COL_W-1:0] col_out_reg;
    pix_t                 tl_out_reg, tr_out_reg, bl_out_reg, br_out_reg;
    logic                 last_out_reg;

    always_comb begin
        rem = head_rec.mask & ~done_reg;
        if (rem[SLOT_UL]) begin
            slot = SLOT_UL;
        end else if (rem[SLOT_UR]) begin
            slot = SLOT_UR;
        end else if (rem[SLOT_LL]) begin
            slot = SLOT_LL;
        end else begin
            slot = SLOT_LR;
        end
        sel_bit   = NUM_SLOTS'(1) << slot;
        rem_after = rem & ~sel_bit;
        finish    = (rem_after == '0);

        load = head_valid && (!m_valid_reg || m_ready);
        pop  = load && finish;

        done_next = done_reg;
        if (load) begin
            done_next = finish ? '0 : (done_reg | sel_bit);
        end

        // Rows above and columns to the left exist whenever those slots are set.
        case (slot)
            SLOT_UL: begin
                w_tl    = head_rec.up_left;
                w_tr    = head_rec.up;
                w_bl    = head_rec.left;
                w_br    = head_rec.cur;
                blk_row = ROW_W'(head_rec.row - ROW_W'(1));
                blk_col = COL_W'(head_rec.col - COL_W'(1));
            end
            SLOT_UR: begin
                w_tl    = head_rec.up;
                w_tr    = head_rec.prior_start;
                w_bl    = head_rec.cur;
                w_br    = head_rec.row_start;
                blk_row = ROW_W'(head_rec.row - ROW_W'(1));
                blk_col = head_rec.col;
            end
            SLOT_LL: begin
                w_tl    = head_rec.left;
                w_tr    = head_rec.cur;
                w_bl    = head_rec.first_left;
                w_br    = head_rec.first_cur;
                blk_row = head_rec.row;
                blk_col = COL_W'(head_rec.col - COL_W'(1));
            end
            default: begin
                w_tl    = head_rec.cur;
                w_tr    = head_rec.row_start;
                w_bl    = head_rec.first_cur;
                w_br    = head_rec.first_start;
                blk_row = head_rec.row;
                blk_col = head_rec.col;
            end
        endcase

        if (w_tl == w_br) begin
            o_tr = w_tl;
            o_br = w_tl;
            o_bl = (w_bl == w_tr) ? w_tl : w_bl;
        end else if (w_bl == w_tr) begin
            o_tr = w_tr;
            o_bl = w_tr;
            o_br = w_tr;
        end else begin
            o_tr = w_tl;
            o_bl = w_tl;
            o_br = w_tl;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            row_out_reg  <= BLK_ROW_W'(blk_row);
            col_out_reg  <= BLK_COL_W'(blk_col);
            tl_out_reg   <= w_tl;
            tr_out_reg   <= o_tr;
            bl_out_reg   <= o_bl;
            br_out_reg   <= o_br;
            last_out_reg <= (slot == SLOT_LR);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_block_row        = row_out_reg;
    assign m_block_column     = col_out_reg;
    assign m_out_top_left     = tl_out_reg;
    assign m_out_top_right    = tr_out_reg;
    assign m_out_bottom_left  = bl_out_reg;
    assign m_out_bottom_right = br_out_reg;
    assign m_last_block       = last_out_reg;

`ifndef ASSERT_OFF
    a_head_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (rem != '0))
        else $error("queue head has no block left to emit");
    a_done_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> (done_reg == '0))
        else $error("block progress kept with no record at the head");
`endif

endmodule

`default_nettype wire

// ===== sim/pixel_art_2x_upscaler_tb.sv =====
// Self-checking testbench of the 2x pixel-art upscaler: directed table, store fill, random phases.
module pixel_art_2x_upscaler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pau_pkg::*;

    typedef struct packed {
        logic [BLK_ROW_W-1:0] row;
        logic [BLK_COL_W-1:0] column;
        pix_t                 top_left;
        pix_t                 top_right;
        pix_t                 bottom_left;
        pix_t                 bottom_right;
        logic                 last;
    } block_t;

    typedef enum logic [0:0] {
        STEP_WRITE = 1'b0,
        STEP_PIXEL = 1'b1
    } step_kind_e;

    // A pixel row carries the pixel in the low bits of value; a typed block replaces the
    // predicted one for that pixel.
    typedef struct packed {
        step_kind_e            kind;
        reg_idx_t              target;
        logic [APB_DATA_W-1:0] value;
        logic                  typed;
        block_t                want;
    } directed_step_t;

    localparam block_t NO_BLOCK = '0;
    localparam int DIRECTED_COUNT = 27;
    localparam int RANDOM_ITEMS = 177;
    localparam int FILL_COLUMNS = 16;
    localparam int PRINT_CAP = 40;

    localparam directed_step_t DIRECTED_STEPS [DIRECTED_COUNT] = '{
        // Reset sizes are 128 x 128, so row 0 gives no blocks.
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h00, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'hFF, 1'b0, NO_BLOCK},
        // Zero sizes count as one; the column counter restarts mid-image.
        '{STEP_WRITE, REG_NUM_COLUMNS, 32'd0,  1'b0, NO_BLOCK},
        '{STEP_WRITE, REG_NUM_ROWS,    32'd0,  1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'hFF, 1'b1,
          '{10'd0, 9'd0, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1}},
        '{STEP_WRITE, REG_TILED_MODE,  32'd1,  1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'hA5, 1'b1,
          '{10'd0, 9'd0, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 1'b1}},
        // Sizes above the limits saturate.
        '{STEP_WRITE, REG_NUM_ROWS,    32'd2047, 1'b0, NO_BLOCK},
        '{STEP_WRITE, REG_NUM_COLUMNS, 32'd1023, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h5A, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'hC3, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h3C, 1'b0, NO_BLOCK},
        // A 3 x 2 tiled image that reaches each equality rule and four blocks per pixel.
        '{STEP_WRITE, REG_NUM_ROWS,    32'd2,  1'b0, NO_BLOCK},
        '{STEP_WRITE, REG_NUM_COLUMNS, 32'd3,  1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h11, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h22, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h33, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h22, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h33, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h11, 1'b0, NO_BLOCK},
        // The row counter overshoots a shrunken row count and restarts at zero.
        '{STEP_WRITE, REG_NUM_ROWS,    32'd3,  1'b0, NO_BLOCK},
        '{STEP_WRITE, REG_NUM_COLUMNS, 32'd2,  1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h80, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h01, 1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'h7F, 1'b0, NO_BLOCK},
        '{STEP_WRITE, REG_NUM_ROWS,    32'd1,  1'b0, NO_BLOCK},
        '{STEP_PIXEL, REG_NUM_ROWS,    32'hFE, 1'b0, NO_BLOCK}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [BLK_ROW_W-1:0]  m_block_row;
    logic [BLK_COL_W-1:0]  m_block_column;
    logic [PIX_W-1:0]      m_out_top_left;
    logic [PIX_W-1:0]      m_out_top_right;
    logic [PIX_W-1:0]      m_out_bottom_left;
    logic [PIX_W-1:0]      m_out_bottom_right;
    logic                  m_last_block;

    // Scaler state as the predictor sees it.
    pix_t               upper_line [MAX_COLUMNS] = '{default: '0};
    pix_t               top_line [MAX_COLUMNS] = '{default: '0};
    pix_t               left_pix = '0;
    pix_t               line_start = '0;
    pix_t               upper_start = '0;
    int                 row_pos = 0;
    int                 col_pos = 0;
    logic [NUM_ROWS_W-1:0] rows_setting = NUM_ROWS_W'(NUM_ROWS_RESET);
    logic [NUM_COLS_W-1:0] cols_setting = NUM_COLS_W'(NUM_COLS_RESET);
    logic               wrap_edges = 1'b0;

    block_t expected_blocks [$];
    block_t fresh_blocks [$];
    pix_t   shades [4];
    int     mismatch_count = 0;
    logic   steady_flow = 1'b0;
    int     ready_left = 0;

    pixel_art_2x_upscaler dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel           (s_pixel),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_block_row       (m_block_row),
        .m_block_column    (m_block_column),
        .m_out_top_left    (m_out_top_left),
        .m_out_top_right   (m_out_top_right),
        .m_out_bottom_left (m_out_bottom_left),
        .m_out_bottom_right(m_out_bottom_right),
        .m_last_block      (m_last_block)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic void append_block(ref block_t blocks[$], input block_t blk);
        blocks.insert(blocks.size(), blk);
    endfunction

    function automatic int effective_size(input int setting, input int limit);
        if (setting < 1) return 1;
        if (setting > limit) return limit;
        return setting;
    endfunction

    function automatic block_t eagle_block(input int r, input int c, input pix_t tl,
                                           input pix_t tr, input pix_t bl, input pix_t br,
                                           input logic last);
        block_t blk;
        blk.row = BLK_ROW_W'(r);
        blk.column = BLK_COL_W'(c);
        blk.top_left = tl;
        blk.last = last;
        if (tl == br) begin
            blk.top_right = tl;
            blk.bottom_right = tl;
            blk.bottom_left = (bl == tr) ? tl : bl;
        end else if (bl == tr) begin
            blk.top_right = tr;
            blk.bottom_left = tr;
            blk.bottom_right = tr;
        end else begin
            blk.top_right = tl;
            blk.bottom_left = tl;
            blk.bottom_right = tl;
        end
        return blk;
    endfunction

    // Advances the scan by one pixel and leaves the blocks it completes in fresh_blocks.
    task automatic upscale_pixel(input pix_t p);
        int   rows;
        int   cols;
        int   r;
        int   c;
        logic last_col;
        logic last_row;
        pix_t zero;
        rows = effective_size(int'(rows_setting), MAX_ROWS);
        cols = effective_size(int'(cols_setting), MAX_COLUMNS);
        zero = '0;
        fresh_blocks.delete();
        if (col_pos >= cols) col_pos = 0;
        if (row_pos >= rows) row_pos = 0;
        r = row_pos;
        c = col_pos;
        last_col = (c + 1 == cols);
        last_row = (r + 1 == rows);
        if (c == 0) begin
            upper_start = line_start;
            line_start = p;
        end
        if (r == 0) top_line[c] = p;
        if (r >= 1) begin
            if (c >= 1) begin
                append_block(fresh_blocks, eagle_block(r - 1, c - 1, upper_line[c - 1],
                                                       upper_line[c], left_pix, p, 1'b0));
            end
            if (last_col) begin
                append_block(fresh_blocks, eagle_block(r - 1, c, upper_line[c],
                                                       wrap_edges ? upper_start : zero, p,
                                                       wrap_edges ? line_start : zero, 1'b0));
            end
        end
        if (c >= 1) upper_line[c - 1] = left_pix;
        if (last_col) upper_line[c] = p;
        if (last_row) begin
            if (c >= 1) begin
                append_block(fresh_blocks, eagle_block(r, c - 1, left_pix, p,
                                                       wrap_edges ? top_line[c - 1] : zero,
                                                       wrap_edges ? top_line[c] : zero,
                                                       1'b0));
            end
            if (last_col) begin
                append_block(fresh_blocks, eagle_block(r, c, p,
                                                       wrap_edges ? line_start : zero,
                                                       wrap_edges ? top_line[c] : zero,
                                                       wrap_edges ? top_line[0] : zero,
                                                       1'b1));
            end
        end
        left_pix = p;
        col_pos = c + 1;
        if (col_pos >= cols) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= rows) row_pos = 0;
        end
    endtask

    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic int receiver_stall();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return $urandom_range(0, 2);
        if (pick < 95) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic void reshuffle_shades();
        foreach (shades[k]) shades[k] = pix_t'($urandom_range(0, 255));
    endfunction

    // Half the pixels repeat a few shades so that the equality rules fire often.
    function automatic pix_t pick_pixel();
        if ($urandom_range(0, 1) == 1) return shades[$urandom_range(0, 3)];
        return pix_t'($urandom_range(0, 255));
    endfunction

    task automatic write_register(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_NUM_ROWS: begin
                rows_setting = value[NUM_ROWS_W-1:0];
            end
            REG_NUM_COLUMNS: begin
                cols_setting = value[NUM_COLS_W-1:0];
            end
            REG_TILED_MODE: begin
                wrap_edges = value[0];
            end
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    task automatic feed_pixel(input pix_t p, input logic typed, input block_t want);
        int gap;
        s_valid <= 1'b1;
        s_pixel <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        upscale_pixel(p);
        if (typed) begin
            append_block(expected_blocks, want);
        end else begin
            foreach (fresh_blocks[k]) append_block(expected_blocks, fresh_blocks[k]);
        end
        gap = steady_flow ? 0 : sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // A pixel that completes no block may still be in the pipeline, so the task waits on
    // after the last block before the registers change.
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input block_t ref_blk);
        if (got !== want) begin
            report_mismatch($sformatf("block at row %0d column %0d: %s is %0h, expected %0h",
                                      ref_blk.row, ref_blk.column, name, got, want));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_left <= 0;
        end else if (steady_flow) begin
            m_ready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            m_ready <= ~m_ready;
            ready_left <= m_ready ? receiver_stall() : $urandom_range(0, 12);
        end
    end

    always @(posedge aclk) begin
        block_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch($sformatf("block transfer at row %0d column %0d not expected",
                                          m_block_row, m_block_column));
            end else begin
                want = expected_blocks.pop_front();
                check_field("block_row", 32'(m_block_row), 32'(want.row), want);
                check_field("block_column", 32'(m_block_column), 32'(want.column), want);
                check_field("out_top_left", 32'(m_out_top_left), 32'(want.top_left), want);
                check_field("out_top_right", 32'(m_out_top_right), 32'(want.top_right), want);
                check_field("out_bottom_left", 32'(m_out_bottom_left),
                            32'(want.bottom_left), want);
                check_field("out_bottom_right", 32'(m_out_bottom_right),
                            32'(want.bottom_right), want);
                check_field("last_block", 32'(m_last_block), 32'(want.last), want);
            end
        end
    end

    initial begin
        int random_fed;
        int burst;
        int waited;
        logic [APB_DATA_W-1:0] cfg_word;
        random_fed = 0;
        waited = 0;
        reshuffle_shades();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            if (DIRECTED_STEPS[i].kind == STEP_WRITE) begin
                wait_until_idle();
                write_register(DIRECTED_STEPS[i].target, DIRECTED_STEPS[i].value);
            end else begin
                feed_pixel(DIRECTED_STEPS[i].value[PIX_W-1:0], DIRECTED_STEPS[i].typed,
                           DIRECTED_STEPS[i].want);
            end
        end

        // One row at the widest random size fills every store entry that the random
        // phase can reach, so size changes in the middle of an image never read an
        // unwritten entry.
        wait_until_idle();
        write_register(REG_NUM_ROWS, 32'd1);
        write_register(REG_NUM_COLUMNS, 32'(FILL_COLUMNS));
        write_register(REG_TILED_MODE, 32'd1);
        reshuffle_shades();
        repeat (FILL_COLUMNS) feed_pixel(pick_pixel(), 1'b0, NO_BLOCK);

        while (random_fed < RANDOM_ITEMS) begin
            wait_until_idle();
            if ($urandom_range(0, 2) != 0) begin
                cfg_word = $urandom();
                burst = $urandom_range(0, 99);
                if (burst < 70) cfg_word[NUM_ROWS_W-1:0] = NUM_ROWS_W'($urandom_range(0, 5));
                else if (burst < 90) cfg_word[NUM_ROWS_W-1:0] = NUM_ROWS_W'($urandom_range(6, 12));
                else cfg_word[NUM_ROWS_W-1:0] = NUM_ROWS_W'($urandom_range(0, 2047));
                write_register(REG_NUM_ROWS, cfg_word);
            end
            if ($urandom_range(0, 2) != 0) begin
                cfg_word = $urandom();
                burst = $urandom_range(0, 99);
                if (burst < 70) cfg_word[NUM_COLS_W-1:0] = NUM_COLS_W'($urandom_range(0, 6));
                else cfg_word[NUM_COLS_W-1:0] = NUM_COLS_W'($urandom_range(7, FILL_COLUMNS));
                write_register(REG_NUM_COLUMNS, cfg_word);
            end
            if ($urandom_range(0, 1) != 0) begin
                write_register(REG_TILED_MODE, $urandom());
            end
            steady_flow <= ($urandom_range(0, 3) == 0);
            reshuffle_shades();
            burst = $urandom_range(3, 40);
            if (burst > RANDOM_ITEMS - random_fed) burst = RANDOM_ITEMS - random_fed;
            repeat (burst) begin
                feed_pixel(pick_pixel(), 1'b0, NO_BLOCK);
                random_fed++;
            end
        end

        s_valid <= 1'b0;
        while (expected_blocks.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (expected_blocks.size() != 0) begin
            report_mismatch($sformatf("%0d expected blocks never arrived",
                                      expected_blocks.size()));
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pau_pkg.sv
hw/rtl/pau_front.sv
hw/rtl/pau_queue.sv
hw/rtl/pau_back.sv
hw/rtl/pixel_art_2x_upscaler.sv
sim/pixel_art_2x_upscaler_tb.sv
